// ===== src/cor_pkg.sv =====
// shared types and constants for the circle outline rasterizer
package cor_pkg;

  // field widths
  localparam int CoordW = 12;
  localparam int RadW   = 11;
  localparam int ColW   = 8;
  localparam int PixW   = 14;
  localparam int StepW  = 13;
  localparam int RsqW   = 25;
  localparam int XsqW   = 26;
  localparam int YbtW   = 27;
  localparam int PtIdxW = 3;

  // index of the eighth point of a group
  localparam logic [PtIdxW-1:0] LastPt = 3'd7;

  // request classification
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  // classified request as held in the queue
  typedef struct packed {
    kind_e                    kind;
    logic [CoordW-1:0]        cx;
    logic [CoordW-1:0]        cy;
    logic [RadW-1:0]          rad;
    logic [3*ColW-1:0]        colour;
    logic [RsqW-1:0]          rs2;
    logic signed [YbtW-1:0]   ybt0;
  } item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

// ===== src/circle_outline_rasterizer_unit.sv =====
// top level of the circle outline rasterizer
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | request   | in_valid_i/in_stall_o | operation, center_x/y, radius, colour
//   out     | point     | out_valid_o/out_stall_i| pixel_x/y, colour, last_of_group, done
//
// a start, or a step while a circle is active, gives eight points at one point per cycle when
// the output is not stalled, through the output register driven by the emission sequencer
// a step with no circle active is dropped by the back stage
// the first point passes the front register, the queue, the circle state and the output register
// reset is asynchronous and clears control only; there is no clearing pass
// an output stall holds the point; the two-entry queue lets the front keep taking requests until it fills
module circle_outline_rasterizer_unit import cor_pkg::*; #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [CoordW-1:0]      center_x_i,
  input  logic [CoordW-1:0]      center_y_i,
  input  logic [RadW-1:0]        radius_i,
  input  logic [ColW-1:0]        red_i,
  input  logic [ColW-1:0]        green_i,
  input  logic [ColW-1:0]        blue_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PixW-1:0] pixel_x_o,
  output logic signed [PixW-1:0] pixel_y_o,
  output logic [ColW-1:0]        out_red_o,
  output logic [ColW-1:0]        out_green_o,
  output logic [ColW-1:0]        out_blue_o,
  output logic                   last_of_group_o,
  output logic                   circle_done_o
);

  logic   push, pop;
  item_t  front_item, queue_item;
  qstat_t qstat;

  // request intake and classification
  cor_front #(
    .CoordWidth(COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .item_o      (front_item)
  );

  // decoupling queue
  cor_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .qstat_o (qstat)
  );

  // iteration and point emission
  cor_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (queue_item),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .last_of_group_o (last_of_group_o),
    .circle_done_o   (circle_done_o)
  );

endmodule

// ===== src/cor_front.sv =====
// front stage: takes requests, classifies them and prepares the start terms
module cor_front import cor_pkg::*; #(
  parameter int CoordWidth = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [CoordW-1:0] center_x_i,
  input  logic [CoordW-1:0] center_y_i,
  input  logic [RadW-1:0]   radius_i,
  input  logic [ColW-1:0]   red_i,
  input  logic [ColW-1:0]   green_i,
  input  logic [ColW-1:0]   blue_i,
  input  qstat_t            qstat_i,
  output logic              push_o,
  output item_t             item_o
);

  localparam logic [CoordW-1:0] CoordMask =
      (CoordWidth >= CoordW) ? {CoordW{1'b1}} : CoordW'((1 << CoordWidth) - 1);

  logic                  valid_q, valid_d;
  logic                  accept;
  kind_e                 kind_q;
  logic [CoordW-1:0]     cx_q, cy_q;
  logic [RadW-1:0]       rad_q;
  logic [3*ColW-1:0]     colour_q;
  logic [2*RadW-1:0]     rad_ext;
  logic [2*RadW-1:0]     rsq_q, rsq_d;
  logic [RsqW-1:0]       rs2;

  // handshake: one holding register ahead of the queue
  assign push_o     = valid_q && !qstat_i.full;
  assign in_stall_o = valid_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // radius squared, registered on accept
  assign rad_ext = {{RadW{1'b0}}, radius_i};
  assign rsq_d   = rad_ext * rad_ext;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= operation_i ? KIND_STEP : KIND_START;
      cx_q     <= center_x_i & CoordMask;
      cy_q     <= center_y_i & CoordMask;
      rad_q    <= radius_i;
      colour_q <= {red_i, green_i, blue_i};
      rsq_q    <= rsq_d;
    end
  end

  // start terms: 4r^2 and 4r^2 - 2r + 1
  assign rs2 = RsqW'({rsq_q, 2'b00});

  always_comb begin
    item_o.kind   = kind_q;
    item_o.cx     = cx_q;
    item_o.cy     = cy_q;
    item_o.rad    = rad_q;
    item_o.colour = colour_q;
    item_o.rs2    = rs2;
    item_o.ybt0   = $signed(YbtW'(rs2)) - $signed(YbtW'({rad_q, 1'b0}))
                    + $signed(YbtW'(1));
  end

endmodule

// ===== src/cor_queue.sv =====
// two-entry queue between the front and back stages
module cor_queue import cor_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t qstat_o
);

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  item_t             entry_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q, cnt_d;

  // occupancy
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o           = entry_q[rd_ptr_q];
  assign qstat_o.full     = (cnt_q == CntW'(QDepth));
  assign qstat_o.nonempty = (cnt_q != '0);

endmodule

// ===== src/cor_back.sv =====
// back stage: midpoint iteration and eight-point emission through an output register
module cor_back import cor_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  item_t                  item_i,
  input  qstat_t                 qstat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PixW-1:0] pixel_x_o,
  output logic signed [PixW-1:0] pixel_y_o,
  output logic [ColW-1:0]        out_red_o,
  output logic [ColW-1:0]        out_green_o,
  output logic [ColW-1:0]        out_blue_o,
  output logic                   last_of_group_o,
  output logic                   circle_done_o
);

  // circle state
  logic [CoordW-1:0]       cx_q, cy_q;
  logic signed [StepW-1:0] x_q, y_q;
  logic [RsqW-1:0]         rs2_q;
  logic signed [XsqW-1:0]  xsq_q;
  logic signed [YbtW-1:0]  ybt_q;
  logic [3*ColW-1:0]       colour_q;
  logic                    active_q, done_q;

  // emission sequencer
  logic                    busy_q, busy_d;
  logic [PtIdxW-1:0]       pt_q, pt_d;

  // output register
  logic                    out_valid_q;
  logic signed [PixW-1:0]  px_q, py_q;
  logic [3*ColW-1:0]       out_col_q;
  logic                    last_q, done_out_q;

  logic                    load_out, slot_free, is_start, emit;
  logic signed [XsqW-1:0]  x8, xsq_step;
  logic signed [StepW-1:0] x_step, y_step;
  logic signed [YbtW-1:0]  y8, slack, ybt_step;
  logic                    dec, done_step;
  logic signed [StepW-1:0] a_sel, b_sel;
  logic                    neg_x, neg_y;
  logic signed [PixW-1:0]  cx_ext, cy_ext, a_ext, b_ext, px, py;

  // handshake between sequencer, queue and output register
  assign load_out  = busy_q && (!out_valid_q || !out_stall_i);
  assign slot_free = !busy_q || (load_out && (pt_q == LastPt));
  assign pop_o     = qstat_i.nonempty && slot_free;
  assign is_start  = (item_i.kind == KIND_START);
  assign emit      = pop_o && (is_start || active_q);

  // one midpoint iteration
  assign x8        = XsqW'(x_q) <<< 3;
  assign xsq_step  = xsq_q + x8 + XsqW'(4);
  assign x_step    = x_q + StepW'(1);
  assign slack     = $signed(YbtW'(rs2_q)) - YbtW'(xsq_step);
  assign dec       = (slack < ybt_q);
  assign y8        = YbtW'(y_q) <<< 3;
  assign ybt_step  = dec ? (ybt_q - y8 + YbtW'(4)) : ybt_q;
  assign y_step    = dec ? (y_q - StepW'(1)) : y_q;
  assign done_step = (x_step > y_step);

  // state update on a popped request
  always_ff @(posedge clk_i) begin
    if (pop_o && is_start) begin
      cx_q     <= item_i.cx;
      cy_q     <= item_i.cy;
      x_q      <= '0;
      y_q      <= $signed(StepW'(item_i.rad));
      rs2_q    <= item_i.rs2;
      xsq_q    <= '0;
      ybt_q    <= item_i.ybt0;
      colour_q <= item_i.colour;
      done_q   <= 1'b0;
    end else if (pop_o && active_q) begin
      x_q      <= x_step;
      y_q      <= y_step;
      xsq_q    <= xsq_step;
      ybt_q    <= ybt_step;
      done_q   <= done_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (pop_o && is_start) begin
      active_q <= 1'b1;
    end else if (pop_o && active_q) begin
      active_q <= !done_step;
    end
  end

  // point sequencer
  always_comb begin
    busy_d = busy_q;
    pt_d   = pt_q;
    if (emit) begin
      busy_d = 1'b1;
      pt_d   = '0;
    end else if (load_out) begin
      pt_d = pt_q + PtIdxW'(1);
      if (pt_q == LastPt) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pt_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pt_q   <= pt_d;
    end
  end

  // point selection: the upper four swap x and y
  assign a_sel  = pt_q[2] ? y_q : x_q;
  assign b_sel  = pt_q[2] ? x_q : y_q;
  assign neg_x  = pt_q[2] ? pt_q[1] : pt_q[0];
  assign neg_y  = pt_q[2] ? pt_q[0] : pt_q[1];
  assign cx_ext = $signed({2'b00, cx_q});
  assign cy_ext = $signed({2'b00, cy_q});
  assign a_ext  = PixW'(a_sel);
  assign b_ext  = PixW'(b_sel);
  assign px     = neg_x ? (cx_ext - a_ext) : (cx_ext + a_ext);
  assign py     = neg_y ? (cy_ext - b_ext) : (cy_ext + b_ext);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      px_q       <= px;
      py_q       <= py;
      out_col_q  <= colour_q;
      last_q     <= (pt_q == LastPt);
      done_out_q <= done_q && (pt_q == LastPt);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign out_red_o       = out_col_q[3*ColW-1:2*ColW];
  assign out_green_o     = out_col_q[2*ColW-1:ColW];
  assign out_blue_o      = out_col_q[ColW-1:0];
  assign last_of_group_o = last_q;
  assign circle_done_o   = done_out_q;

endmodule

// ===== src/cor_checker.sv =====
// port-level checker for the circle outline rasterizer, with its bind
module cor_checker import cor_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [PixW-1:0] pixel_x_o,
  input logic signed [PixW-1:0] pixel_y_o,
  input logic                   last_of_group_o,
  input logic                   circle_done_o
);

  logic              out_take;
  logic [PtIdxW-1:0] taken_q;

  assign out_take = out_valid_o && !out_stall_i;

  // position of the next point within its group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (out_take) begin
      taken_q <= taken_q + PtIdxW'(1);
    end
  end

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o)
      && $stable(pixel_y_o) && $stable(last_of_group_o) && $stable(circle_done_o))
    else $error("stalled point changed");

  // done only on the closing point of a group
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && circle_done_o |-> last_of_group_o)
    else $error("circle done without group end");

  // groups are always eight points long
  a_group_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_take |-> (last_of_group_o == (taken_q == LastPt)))
    else $error("group length is not eight");

  // no point straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
      !rst_ni |=> !out_valid_o)
    else $error("point shown after reset");

endmodule

bind circle_outline_rasterizer_unit cor_checker u_cor_checker (.*);
